// ===== design/rie_pkg.sv =====
// Shared types, opcodes and constants of the RISC instruction executor.
package rie_pkg;

	localparam int unsigned MEM_WORDS_DEF = 2048;
	localparam int unsigned NUM_REGS      = 32;
	localparam int unsigned IN_TDATA_W    = 32;
	localparam int unsigned OUT_TDATA_W   = 120;

	typedef logic [4:0] reg_idx_t;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MULI = 4'd2,
		OP_ADDI = 4'd3,
		OP_BNE  = 4'd4,
		OP_ANDI = 4'd5,
		OP_ORI  = 4'd6,
		OP_J    = 4'd7,
		OP_SLL  = 4'd8,
		OP_SRL  = 4'd9,
		OP_LW   = 4'd10,
		OP_SW   = 4'd11
	} opcode_t;

	typedef struct packed {
		logic        en;
		reg_idx_t    addr;
		logic [31:0] data;
	} rf_wr_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        branch_taken;
		logic        reg_write;
		reg_idx_t    dest_reg;
		logic [31:0] write_value;
		logic        mem_write;
		logic        mem_read;
		logic [31:0] mem_address;
		logic [31:0] store_value;
		logic        bad_opcode;
	} exe_res_t;

	// first read port: r3 for register-register ops, r1 otherwise
	function automatic reg_idx_t src_a_idx(input logic [31:0] word);
		opcode_t op;
		op = opcode_t'(word[31:28]);
		if (op == OP_ADD || op == OP_SUB) begin
			return word[17:13];
		end
		return word[27:23];
	endfunction

	function automatic reg_idx_t src_b_idx(input logic [31:0] word);
		return word[22:18];
	endfunction

endpackage

// ===== design/rie_ram.sv =====
// Generic RAM with one write port and one registered read port.
module rie_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/rie_regfile.sv =====
// Register file: two read ports over RAM copies, valid bits and same-edge write bypass.
module rie_regfile (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  rie_pkg::reg_idx_t rd_addr_a,
	input  rie_pkg::reg_idx_t rd_addr_b,
	input  rie_pkg::rf_wr_t  wr,
	output logic [31:0]      rd_data_a,
	output logic [31:0]      rd_data_b
);

	import rie_pkg::*;

	logic [NUM_REGS-1:0] valid_q;
	logic                vld_a_q, vld_b_q;
	logic                hit_a_q, hit_b_q;
	logic [31:0]         byp_q;
	logic [31:0]         ram_a, ram_b;

	rie_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_ram_a (
		.clk  (clk),
		.we   (wr.en),
		.waddr(wr.addr),
		.wdata(wr.data),
		.re   (rd_en),
		.raddr(rd_addr_a),
		.rdata(ram_a)
	);

	rie_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_ram_b (
		.clk  (clk),
		.we   (wr.en),
		.waddr(wr.addr),
		.wdata(wr.data),
		.re   (rd_en),
		.raddr(rd_addr_b),
		.rdata(ram_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
			hit_a_q <= 1'b0;
			hit_b_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_a_q <= valid_q[rd_addr_a];
				vld_b_q <= valid_q[rd_addr_b];
				hit_a_q <= wr.en && (wr.addr == rd_addr_a);
				hit_b_q <= wr.en && (wr.addr == rd_addr_b);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			byp_q <= wr.data;
		end
	end

	assign rd_data_a = hit_a_q ? byp_q : (vld_a_q ? ram_a : '0);
	assign rd_data_b = hit_b_q ? byp_q : (vld_b_q ? ram_b : '0);

endmodule

// ===== design/rie_exec.sv =====
// Execute unit: decode, ALU, branch and address logic for one instruction.
module rie_exec #(
	parameter int unsigned MEM_WORDS = rie_pkg::MEM_WORDS_DEF
) (
	input  logic [31:0]       instr,
	input  logic [31:0]       pc,
	input  logic [31:0]       opa,
	input  logic [31:0]       opb,
	output rie_pkg::exe_res_t res
);

	import rie_pkg::*;

	localparam logic [31:0] ADDR_MASK = 32'(MEM_WORDS - 1);

	opcode_t     op;
	reg_idx_t    r1;
	logic [12:0] shamt;
	logic [31:0] imm;
	logic [31:0] pc1;
	logic [31:0] sum_b_imm;
	logic [31:0] prod;
	logic [31:0] val;
	logic        wr;

	assign op        = opcode_t'(instr[31:28]);
	assign r1        = instr[27:23];
	assign shamt     = instr[12:0];
	assign imm       = {{14{instr[17]}}, instr[17:0]};
	assign pc1       = pc + 32'd1;
	assign sum_b_imm = opb + imm;
	assign prod      = opb * imm;

	always_comb begin
		res         = '0;
		res.next_pc = pc1;
		val         = '0;
		wr          = 1'b0;
		unique case (op)
			OP_ADD: begin
				val = opb + opa;
				wr  = 1'b1;
			end
			OP_SUB: begin
				val = opb - opa;
				wr  = 1'b1;
			end
			OP_MULI: begin
				val = prod;
				wr  = 1'b1;
			end
			OP_ADDI: begin
				val = sum_b_imm;
				wr  = 1'b1;
			end
			OP_BNE: begin
				if (opa != opb) begin
					res.next_pc      = pc1 + imm;
					res.branch_taken = 1'b1;
				end
			end
			OP_ANDI: begin
				val = opb & imm;
				wr  = 1'b1;
			end
			OP_ORI: begin
				val = opb | imm;
				wr  = 1'b1;
			end
			OP_J: begin
				res.next_pc      = {pc1[31:28], instr[27:0]};
				res.branch_taken = 1'b1;
			end
			OP_SLL: begin
				val = (shamt >= 13'd32) ? '0 : (opb << shamt[4:0]);
				wr  = 1'b1;
			end
			OP_SRL: begin
				val = (shamt >= 13'd32) ? '0 : (opb >> shamt[4:0]);
				wr  = 1'b1;
			end
			OP_LW: begin
				res.mem_read    = 1'b1;
				res.mem_address = sum_b_imm & ADDR_MASK;
				wr              = 1'b1;
			end
			OP_SW: begin
				res.mem_write   = 1'b1;
				res.mem_address = sum_b_imm & ADDR_MASK;
				res.store_value = opa;
			end
			default: begin
				res.bad_opcode = 1'b1;
			end
		endcase
		if (wr && r1 != '0) begin
			res.reg_write   = 1'b1;
			res.dest_reg    = r1;
			res.write_value = val;
		end
	end

endmodule

// ===== design/risc_instruction_executor_top.sv =====
// Top level of the RISC instruction executor: pipeline, data memory and stream ports.
//
// Executes one instruction word per cycle in program order unless the result port
// stalls; each word yields one result word after register read, then execute and
// memory access, then the output register. Results of earlier instructions, including
// loads, are forwarded, so dependent instructions run back to back without stalls.
// After reset the data memory is cleared one word per cycle, so no instruction is
// taken until the clear ends. MEM_WORDS must be a power of two; addresses wrap at it.
module risc_instruction_executor_top #(
	parameter int unsigned MEM_WORDS = rie_pkg::MEM_WORDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// instruction_word
	input  logic [rie_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// next_pc, branch_taken, reg_write, dest_reg, write_value, mem_write,
	// mem_address, store_value, bad_opcode, zero pad
	output logic [rie_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	import rie_pkg::*;

	localparam int unsigned AW = $clog2(MEM_WORDS);

	logic          accept;
	logic          out_free, s2_free;
	logic          ld_s2, ld_s3;
	logic          valid_s1, valid_s2, valid_s3;
	logic [31:0]   instr_s1;
	exe_res_t      res_s2, res_s3;
	exe_res_t      exe_res;
	logic [31:0]   pc_q;
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;
	logic [31:0]   rf_a, rf_b;
	logic [31:0]   opa, opb;
	logic [31:0]   fin_s2;
	logic [31:0]   dmem_q;
	rf_wr_t        rf_wr;
	reg_idx_t      src_a_s1, src_b_s1;
	logic          dm_we;
	logic [AW-1:0] dm_addr;
	logic [31:0]   dm_wdata;

	assign out_free      = !valid_s3 || m_axis_tready;
	assign ld_s3         = valid_s2 && out_free;
	assign s2_free       = !valid_s2 || out_free;
	assign ld_s2         = valid_s1 && s2_free;
	assign s_axis_tready = !clr_busy_q && (!valid_s1 || s2_free);
	assign accept        = s_axis_tvalid && s_axis_tready;

	rie_regfile u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr_a(src_a_idx(s_axis_tdata)),
		.rd_addr_b(src_b_idx(s_axis_tdata)),
		.wr       (rf_wr),
		.rd_data_a(rf_a),
		.rd_data_b(rf_b)
	);

	assign fin_s2   = (res_s2.mem_read && res_s2.reg_write) ? dmem_q : res_s2.write_value;
	assign src_a_s1 = src_a_idx(instr_s1);
	assign src_b_s1 = src_b_idx(instr_s1);

	assign opa = (valid_s2 && res_s2.reg_write && res_s2.dest_reg == src_a_s1) ? fin_s2 : rf_a;
	assign opb = (valid_s2 && res_s2.reg_write && res_s2.dest_reg == src_b_s1) ? fin_s2 : rf_b;

	rie_exec #(.MEM_WORDS(MEM_WORDS)) u_exec (
		.instr(instr_s1),
		.pc   (pc_q),
		.opa  (opa),
		.opb  (opb),
		.res  (exe_res)
	);

	assign dm_we    = clr_busy_q || (ld_s2 && exe_res.mem_write);
	assign dm_addr  = clr_busy_q ? clr_addr_q : exe_res.mem_address[AW-1:0];
	assign dm_wdata = clr_busy_q ? '0 : exe_res.store_value;

	rie_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
		.clk  (clk),
		.we   (dm_we),
		.waddr(dm_addr),
		.wdata(dm_wdata),
		.re   (ld_s2 && exe_res.mem_read),
		.raddr(dm_addr),
		.rdata(dmem_q)
	);

	always_comb begin
		rf_wr.en   = ld_s3 && res_s2.reg_write;
		rf_wr.addr = res_s2.dest_reg;
		rf_wr.data = fin_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			pc_q       <= '0;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !ld_s2);
			valid_s2 <= ld_s2 || (valid_s2 && !ld_s3);
			valid_s3 <= ld_s3 || (valid_s3 && !m_axis_tready);
			if (ld_s2) begin
				pc_q <= exe_res.next_pc;
			end
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(MEM_WORDS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1 <= s_axis_tdata;
		end
		if (ld_s2) begin
			res_s2 <= exe_res;
		end
		if (ld_s3) begin
			res_s3             <= res_s2;
			res_s3.write_value <= fin_s2;
		end
	end

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = {4'b0000, res_s3.bad_opcode, res_s3.store_value,
		res_s3.mem_address[10:0], res_s3.mem_write, res_s3.write_value,
		res_s3.dest_reg, res_s3.reg_write, res_s3.branch_taken, res_s3.next_pc};

`ifndef ASSERT_OFF
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !s_axis_tready)
		else $error("word accepted during memory clear");

	a_no_r0_write: assert property (@(posedge clk) disable iff (!arst_n)
		rf_wr.en |-> rf_wr.addr != '0)
		else $error("register zero written");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_free) |-> !ld_s2)
		else $error("stage two overwritten while stalled");

	a_pc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ld_s2 |=> $stable(pc_q))
		else $error("program counter moved without an executed word");
`endif

endmodule
